### sv/pol_pkg.sv
package pol_pkg;

    localparam int CAPACITY = 32;

    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W = $clog2(CAPACITY + 1);

    localparam logic [MODE_W-1:0] MODE_INS_FIRST = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_LAST  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_FIRST = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_LAST  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_DISPLAY   = 3'd6;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

    typedef struct packed {
        logic exec;        // run one insert/delete/other op and load its result
        logic disp_start;  // begin a display walk at the head
        logic disp_emit;   // load the current display element
    } pol_cmd_t;

    typedef struct packed {
        logic slot_free;   // output register can take a result this cycle
        logic empty;
        logic disp_last;   // current display index is the tail
    } pol_stat_t;

endpackage

### sv/pol_ctrl.sv
module pol_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pol_pkg::MODE_W-1:0]    mode,
    input  pol_pkg::pol_stat_t            stat,
    output pol_pkg::pol_cmd_t             cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DISP = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = stat.slot_free;
                if (in_valid && stat.slot_free)
                begin
                    if (mode == pol_pkg::MODE_DISPLAY && !stat.empty)
                    begin
                        cmd.disp_start = 1'b1;
                        state_next     = ST_DISP;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            ST_DISP:
            begin
                if (stat.slot_free)
                begin
                    cmd.disp_emit = 1'b1;
                    if (stat.disp_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/pol_datapath.sv
module pol_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [pol_pkg::MODE_W-1:0]         mode,
    input  logic signed [pol_pkg::VALUE_W-1:0] value,
    input  logic [pol_pkg::POS_W-1:0]          position,
    input  pol_pkg::pol_cmd_t                  cmd,
    output pol_pkg::pol_stat_t                 stat,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pol_pkg::STAT_W-1:0]         status,
    output logic [pol_pkg::COUNT_W-1:0]        count,
    output logic signed [pol_pkg::VALUE_W-1:0] element,
    output logic                               element_valid,
    output logic                               last
);

    logic signed [pol_pkg::VALUE_W-1:0] cell_reg  [pol_pkg::CAPACITY];
    logic signed [pol_pkg::VALUE_W-1:0] cell_next [pol_pkg::CAPACITY];

    logic [pol_pkg::LEN_W-1:0] length_reg, length_next;
    logic [pol_pkg::IDX_W-1:0] idx_reg, idx_next;

    logic                               out_valid_reg, out_valid_next;
    logic [pol_pkg::STAT_W-1:0]         status_reg, status_next;
    logic [pol_pkg::LEN_W-1:0]          count_reg, count_next;
    logic signed [pol_pkg::VALUE_W-1:0] element_reg, element_next;
    logic                               element_valid_reg, element_valid_next;
    logic                               last_reg, last_next;

    logic                       is_ins, is_del;
    logic [pol_pkg::POS_W-1:0]  p_sel, len_ext, pm1;
    logic [pol_pkg::IDX_W-1:0]  k;
    logic                       ins_bad, full, empty, del_bad;
    logic [pol_pkg::STAT_W-1:0] op_status;
    logic                       do_ins, do_del;
    logic [pol_pkg::LEN_W-1:0]  len_op;

    assign len_ext = pol_pkg::POS_W'(length_reg);
    assign empty   = (length_reg == '0);
    assign full    = (length_reg >= pol_pkg::LEN_W'(pol_pkg::CAPACITY));

    // decode the target position of the op
    always_comb
    begin
        is_ins = 1'b0;
        is_del = 1'b0;
        p_sel  = position;
        unique case (mode)
            pol_pkg::MODE_INS_FIRST:
            begin
                is_ins = 1'b1;
                p_sel  = pol_pkg::POS_W'(1);
            end
            pol_pkg::MODE_INS_LAST:
            begin
                is_ins = 1'b1;
                p_sel  = len_ext + pol_pkg::POS_W'(1);
            end
            pol_pkg::MODE_INS_POS:
            begin
                is_ins = 1'b1;
            end
            pol_pkg::MODE_DEL_FIRST:
            begin
                is_del = 1'b1;
                p_sel  = pol_pkg::POS_W'(1);
            end
            pol_pkg::MODE_DEL_LAST:
            begin
                is_del = 1'b1;
                p_sel  = len_ext;
            end
            pol_pkg::MODE_DEL_POS:
            begin
                is_del = 1'b1;
            end
            default:
            begin
                p_sel = position;
            end
        endcase
    end

    assign ins_bad = (p_sel == '0) || (p_sel > len_ext + pol_pkg::POS_W'(1));
    assign del_bad = (p_sel == '0) || (p_sel > len_ext);
    assign pm1     = p_sel - pol_pkg::POS_W'(1);
    assign k       = pm1[pol_pkg::IDX_W-1:0];

    always_comb
    begin
        op_status = pol_pkg::STAT_OK;
        do_ins    = 1'b0;
        do_del    = 1'b0;
        if (is_ins)
        begin
            if (ins_bad)
                op_status = pol_pkg::STAT_BADPOS;
            else if (full)
                op_status = pol_pkg::STAT_FULL;
            else
                do_ins = 1'b1;
        end
        else if (is_del)
        begin
            if (empty)
                op_status = pol_pkg::STAT_EMPTY;
            else if (del_bad)
                op_status = pol_pkg::STAT_BADPOS;
            else
                do_del = 1'b1;
        end
        else if (mode == pol_pkg::MODE_DISPLAY)
        begin
            // only reaches exec with an empty list
            op_status = pol_pkg::STAT_EMPTY;
        end
    end

    always_comb
    begin
        len_op = length_reg;
        if (do_ins)
            len_op = length_reg + pol_pkg::LEN_W'(1);
        else if (do_del)
            len_op = length_reg - pol_pkg::LEN_W'(1);
    end

    // cell chain: each cell takes the new value, its front or back neighbor, or holds
    for (genvar g = 0; g < pol_pkg::CAPACITY; g++)
    begin : g_cell
        localparam logic [pol_pkg::IDX_W-1:0] G_IDX = pol_pkg::IDX_W'(g);
        logic signed [pol_pkg::VALUE_W-1:0] from_front, from_back;

        if (g == 0)
        begin : g_head
            assign from_front = cell_reg[g];
        end
        else
        begin : g_mid
            assign from_front = cell_reg[g-1];
        end

        if (g == pol_pkg::CAPACITY - 1)
        begin : g_tail
            assign from_back = cell_reg[g];
        end
        else
        begin : g_body
            assign from_back = cell_reg[g+1];
        end

        always_comb
        begin
            cell_next[g] = cell_reg[g];
            if (cmd.exec && do_ins)
            begin
                if (G_IDX == k)
                    cell_next[g] = value;
                else if (G_IDX > k)
                    cell_next[g] = from_front;
            end
            else if (cmd.exec && do_del)
            begin
                if (G_IDX >= k)
                    cell_next[g] = from_back;
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[g] <= cell_next[g];
        end
    end

    assign stat.slot_free = !out_valid_reg || out_ready;
    assign stat.empty     = empty;
    assign stat.disp_last = (pol_pkg::LEN_W'(idx_reg) + pol_pkg::LEN_W'(1)) == length_reg;

    always_comb
    begin
        length_next        = length_reg;
        idx_next           = idx_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        status_next        = status_reg;
        count_next         = count_reg;
        element_next       = element_reg;
        element_valid_next = element_valid_reg;
        last_next          = last_reg;
        if (cmd.exec)
        begin
            length_next        = len_op;
            out_valid_next     = 1'b1;
            status_next        = op_status;
            count_next         = len_op;
            element_next       = '0;
            element_valid_next = 1'b0;
            last_next          = 1'b1;
        end
        else if (cmd.disp_start)
        begin
            idx_next = '0;
        end
        else if (cmd.disp_emit)
        begin
            idx_next           = idx_reg + pol_pkg::IDX_W'(1);
            out_valid_next     = 1'b1;
            status_next        = pol_pkg::STAT_OK;
            count_next         = length_reg;
            element_next       = cell_reg[idx_reg];
            element_valid_next = 1'b1;
            last_next          = stat.disp_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg        <= status_next;
        count_reg         <= count_next;
        element_reg       <= element_next;
        element_valid_reg <= element_valid_next;
        last_reg          <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign count         = pol_pkg::COUNT_W'(count_reg);
    assign element       = element_reg;
    assign element_valid = element_valid_reg;
    assign last          = last_reg;

endmodule

### sv/positional_ordered_list.sv
// insert, delete and other ops: one transaction per cycle unless stalled, result next cycle
// display of n elements: accepted, then one element per cycle unless the output stalls
// the shifting cell chain moves the entries from the target position on at acceptance;
// display walks one read index through the cells, one element per output transaction
// reset clears the length, the display index and the output valid; cells are not reset
module positional_ordered_list (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pol_pkg::MODE_W-1:0]         mode,
    input  logic signed [pol_pkg::VALUE_W-1:0] value,
    input  logic [pol_pkg::POS_W-1:0]          position,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pol_pkg::STAT_W-1:0]         status,
    output logic [pol_pkg::COUNT_W-1:0]        count,
    output logic signed [pol_pkg::VALUE_W-1:0] element,
    output logic                               element_valid,
    output logic                               last
);

    pol_pkg::pol_cmd_t  cmd;
    pol_pkg::pol_stat_t stat;

    pol_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    pol_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .value         (value),
        .position      (position),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .count         (count),
        .element       (element),
        .element_valid (element_valid),
        .last          (last)
    );

endmodule

### sv/pol_checker.sv
module pol_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [pol_pkg::MODE_W-1:0]         mode,
    input logic signed [pol_pkg::VALUE_W-1:0] value,
    input logic [pol_pkg::POS_W-1:0]          position,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [pol_pkg::STAT_W-1:0]         status,
    input logic [pol_pkg::COUNT_W-1:0]        count,
    input logic signed [pol_pkg::VALUE_W-1:0] element,
    input logic                               element_valid,
    input logic                               last
);

    // a new transaction is only taken when the result slot frees up
    a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!out_valid || out_ready))
        else $error("input taken while result slot blocked");

    // any non-display op gives exactly one closing result next cycle
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode != pol_pkg::MODE_DISPLAY)
        |=> (out_valid && last && !element_valid))
        else $error("single-result op did not produce its result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= pol_pkg::COUNT_W'(pol_pkg::CAPACITY)))
        else $error("count above capacity");

    a_status_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !element_valid) |-> last)
        else $error("status-only result not marked last");

    a_element_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && element_valid) |-> (status == pol_pkg::STAT_OK))
        else $error("displayed element with error status");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (.*);
